@@ src/atsp_pkg.sv @@
// Types, layer tables and helper functions for the standard-atmosphere pressure pipeline.
package atsp_pkg;

   // Layer table size and default layer count
   localparam int LAYER_CAP      = 7;
   localparam int NUM_LAYERS_DEF = 7;

   // Field widths
   localparam int ALT_W   = 21;
   localparam int PRES_W  = 27;
   localparam int LAYER_W = 3;

   localparam logic [PRES_W-1:0] P_MAX = {PRES_W{1'b1}};

   // Log pipeline: one fraction bit per squaring stage
   localparam int LG_N = 24;

   // Square-root chain: 24 roots, 32 digit steps each, SQ_STEPS steps per stage
   localparam int SQ_STEPS  = 4;
   localparam int SQ_SUB    = 32 / SQ_STEPS;
   localparam int SQ_STAGES = LG_N * SQ_SUB;

   // Scale shift limits: shift = 36 - n, valid for 0..63
   localparam logic signed [15:0] N_SAT_ABOVE = 16'sd36;
   localparam logic signed [15:0] N_ZERO_BELOW = -16'sd27;

   // Layer bases in decimetres
   localparam logic signed [ALT_W-1:0] BASE_DM [LAYER_CAP] = '{
      21'sd0, 21'sd110000, 21'sd200000, 21'sd320000, 21'sd470000, 21'sd510000, 21'sd710000};

   // Base temperatures, units of 1e-5 K
   localparam logic [24:0] BASE_TEMP [LAYER_CAP] = '{
      25'd28815000, 25'd21665000, 25'd21665000, 25'd22865000,
      25'd27065000, 25'd27065000, 25'd21465000};

   // Lapse rates, 1e-5 K per decimetre
   localparam logic signed [7:0] LAPSE [LAYER_CAP] = '{
      -8'sd65, 8'sd0, 8'sd10, 8'sd28, 8'sd0, -8'sd28, -8'sd20};

   localparam logic ISOTHERMAL [LAYER_CAP] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

   // Power-law exponent K/L, Q24
   localparam logic signed [30:0] GRAD_EXP [LAYER_CAP] = '{
      -31'sd88178957, 31'sd0, 31'sd573163218, 31'sd204701150,
      31'sd0, -31'sd204701150, -31'sd286581609};

   // Isothermal decay per decimetre, Q40
   localparam logic [24:0] ISO_COEF [LAYER_CAP] = '{
      25'd0, 25'd25013478, 25'd0, 25'd0, 25'd20022797, 25'd0, 25'd0};

   // Base pressures, Q24 hPa
   localparam logic [33:0] BASE_P [LAYER_CAP] = '{
      34'd16999514112, 34'd3797029591, 34'd918533953, 34'd145629372,
      34'd18606990, 34'd11230479, 34'd663777};

   // Q24 log2 by repeated squaring, evaluated for constants only
   function automatic logic [28:0] log2_q24_f(input logic [63:0] v);
      int          e;
      logic [63:0] m;
      logic [23:0] fr;
      e  = 0;
      fr = '0;
      for (int b = 0; b < 64; b++) begin
         if (v[b]) e = b;
      end
      if (e >= 30) m = v >> (e - 30);
      else m = v << (30 - e);
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m[31]) begin
            m     = m >> 1;
            fr[i] = 1'b1;
         end
      end
      return {5'(e), fr};
   endfunction

   localparam logic [28:0] LOG2_TB [LAYER_CAP] = '{
      log2_q24_f(64'(BASE_TEMP[0])), log2_q24_f(64'(BASE_TEMP[1])),
      log2_q24_f(64'(BASE_TEMP[2])), log2_q24_f(64'(BASE_TEMP[3])),
      log2_q24_f(64'(BASE_TEMP[4])), log2_q24_f(64'(BASE_TEMP[5])),
      log2_q24_f(64'(BASE_TEMP[6]))};

   // Channel payloads
   typedef struct packed {
      logic signed [ALT_W-1:0] altitude_dm;
      logic                    last_in;
   } req_type;

   typedef struct packed {
      logic [PRES_W-1:0]  pressure_q16;
      logic [LAYER_W-1:0] layer_index;
      logic               last_out;
   } rsp_type;

   // Log2 pipeline record
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [LAYER_W-1:0]   layer;
      logic                 iso;
      logic signed [39:0]   xiso;
      logic [4:0]           e;
      logic [30:0]          m;
      logic [23:0]          fr;
   } lg_type;

   // Square-root chain record
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [LAYER_W-1:0]   layer;
      logic                 sat;
      logic                 zero;
      logic [5:0]           s;
      logic [23:0]          f;
      logic [63:0]          rad;
      logic [33:0]          rem;
      logic [31:0]          root;
   } sq_type;

   // SQ_STEPS digit steps of a restoring integer square root
   function automatic sq_type sq_steps(input sq_type a);
      sq_type      o;
      logic [35:0] rem2;
      logic [35:0] trial;
      o = a;
      for (int i = 0; i < SQ_STEPS; i++) begin
         rem2  = {o.rem, o.rad[63:62]};
         trial = {2'b00, o.root, 2'b01};
         if (rem2 >= trial) begin
            o.rem  = 34'(rem2 - trial);
            o.root = {o.root[30:0], 1'b1};
         end else begin
            o.rem  = rem2[33:0];
            o.root = {o.root[30:0], 1'b0};
         end
         o.rad = {o.rad[61:0], 2'b00};
      end
      return o;
   endfunction

endpackage

@@ src/altitude_to_standard_pressure.sv @@
// Standard-atmosphere pressure from geopotential altitude, fully pipelined.
//
//  channel  | ports                          | transfer
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, req_data          | edge with start high, busy low
//  response | rsp_strobe, rsp_data           | edge ending the strobe cycle
//
// One item enters per clock; busy stays low outside reset.
// A result passes 3 setup stages, 1 normalize stage and 24 squaring stages
// for log2 of the temperature, 3 exponent stages, 192 stages of the 24-root
// chain for 2^frac (4 digit steps a stage) and 2 scaling stages.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module altitude_to_standard_pressure #(
   parameter int NUM_LAYERS = atsp_pkg::NUM_LAYERS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  atsp_pkg::req_type req_data,
   output logic              rsp_strobe,
   output atsp_pkg::rsp_type rsp_data
);

   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // Input register
   logic                                a_valid_ff;
   logic                                a_last_ff;
   logic signed [atsp_pkg::ALT_W-1:0]   a_alt_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else a_valid_ff <= accept;
      a_alt_ff  <= req_data.altitude_dm;
      a_last_ff <= req_data.last_in;
   end

   // Layer select and altitude above layer base
   logic [atsp_pkg::LAYER_W-1:0] layer_in;
   logic signed [21:0]           dh_in;
   logic                         b_valid_ff;
   logic                         b_last_ff;
   logic [atsp_pkg::LAYER_W-1:0] b_layer_ff;
   logic signed [21:0]           b_dh_ff;

   always_comb begin
      layer_in = '0;
      for (int i = 1; i < NUM_LAYERS; i++) begin
         if (a_alt_ff >= atsp_pkg::BASE_DM[i]) layer_in = atsp_pkg::LAYER_W'(i);
      end
      dh_in = 22'(a_alt_ff) - 22'(atsp_pkg::BASE_DM[layer_in]);
   end

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else b_valid_ff <= a_valid_ff;
      b_last_ff  <= a_last_ff;
      b_layer_ff <= layer_in;
      b_dh_ff    <= dh_in;
   end

   // Temperature with floor, and isothermal exponent
   logic signed [29:0] t_prod;
   logic signed [31:0] t_sum;
   logic [26:0]        t_in;
   logic signed [47:0] iso_prod;
   logic signed [48:0] iso_neg;
   logic signed [39:0] xiso_in;
   logic               c_valid_ff;
   logic               c_last_ff;
   logic [atsp_pkg::LAYER_W-1:0] c_layer_ff;
   logic [26:0]        c_t_ff;
   logic signed [39:0] c_xiso_ff;

   always_comb begin
      t_prod   = 30'(atsp_pkg::LAPSE[b_layer_ff]) * 30'(b_dh_ff);
      t_sum    = 32'(t_prod) + 32'($signed({1'b0, atsp_pkg::BASE_TEMP[b_layer_ff]}));
      t_in     = (t_sum < 32'sd1) ? 27'd1 : t_sum[26:0];
      iso_prod = 48'(b_dh_ff) * 48'($signed({1'b0, atsp_pkg::ISO_COEF[b_layer_ff]}));
      iso_neg  = -49'(iso_prod);
      xiso_in  = 40'(iso_neg >>> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else c_valid_ff <= b_valid_ff;
      c_last_ff  <= b_last_ff;
      c_layer_ff <= b_layer_ff;
      c_t_ff     <= t_in;
      c_xiso_ff  <= xiso_in;
   end

   // Normalize temperature: msb index and Q30 mantissa
   atsp_pkg::lg_type lg_ff [atsp_pkg::LG_N+1];
   atsp_pkg::lg_type lg0_in;
   logic [4:0]       msb;

   always_comb begin
      msb = '0;
      for (int i = 0; i < 27; i++) begin
         if (c_t_ff[i]) msb = 5'(i);
      end
      lg0_in       = '0;
      lg0_in.valid = c_valid_ff;
      lg0_in.last  = c_last_ff;
      lg0_in.layer = c_layer_ff;
      lg0_in.iso   = atsp_pkg::ISOTHERMAL[c_layer_ff];
      lg0_in.xiso  = c_xiso_ff;
      lg0_in.e     = msb;
      lg0_in.m     = 31'({4'b0, c_t_ff} << (5'd30 - msb));
   end

   always_ff @(posedge clock) begin
      if (reset) lg_ff[0].valid <= 1'b0;
      else lg_ff[0] <= lg0_in;
   end

   // One fraction bit per stage by squaring the mantissa
   genvar k;
   generate
      for (k = 1; k <= atsp_pkg::LG_N; k++) begin : g_lg
         atsp_pkg::lg_type lg_in;
         logic [61:0]      sq;
         logic [31:0]      q;

         always_comb begin
            lg_in = lg_ff[k-1];
            sq    = 62'(lg_ff[k-1].m) * 62'(lg_ff[k-1].m);
            q     = sq[61:30];
            if (q[31]) begin
               lg_in.m                        = q[31:1];
               lg_in.fr[atsp_pkg::LG_N - k]   = 1'b1;
            end else begin
               lg_in.m = q[30:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) lg_ff[k].valid <= 1'b0;
            else lg_ff[k] <= lg_in;
         end
      end
   endgenerate

   // Log difference against the base temperature
   atsp_pkg::lg_type   lg_end;
   logic signed [29:0] diff_in;
   logic               d_valid_ff;
   logic               d_last_ff;
   logic [atsp_pkg::LAYER_W-1:0] d_layer_ff;
   logic               d_iso_ff;
   logic signed [39:0] d_xiso_ff;
   logic signed [29:0] d_diff_ff;

   assign lg_end  = lg_ff[atsp_pkg::LG_N];
   assign diff_in = $signed({1'b0, atsp_pkg::LOG2_TB[lg_end.layer]})
                  - $signed({1'b0, lg_end.e, lg_end.fr});

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else d_valid_ff <= lg_end.valid;
      d_last_ff  <= lg_end.last;
      d_layer_ff <= lg_end.layer;
      d_iso_ff   <= lg_end.iso;
      d_xiso_ff  <= lg_end.xiso;
      d_diff_ff  <= diff_in;
   end

   // Power-law exponent as two partial products
   logic signed [15:0] gexp_hi;
   logic signed [15:0] gexp_lo;
   logic signed [45:0] ph_in;
   logic signed [45:0] pl_in;
   logic               g1_valid_ff;
   logic               g1_last_ff;
   logic [atsp_pkg::LAYER_W-1:0] g1_layer_ff;
   logic               g1_iso_ff;
   logic signed [39:0] g1_xiso_ff;
   logic signed [45:0] g1_ph_ff;
   logic signed [45:0] g1_pl_ff;

   always_comb begin
      gexp_hi = $signed(atsp_pkg::GRAD_EXP[d_layer_ff][30:15]);
      gexp_lo = $signed({1'b0, atsp_pkg::GRAD_EXP[d_layer_ff][14:0]});
      ph_in   = 46'(d_diff_ff) * 46'(gexp_hi);
      pl_in   = 46'(d_diff_ff) * 46'(gexp_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) g1_valid_ff <= 1'b0;
      else g1_valid_ff <= d_valid_ff;
      g1_last_ff  <= d_last_ff;
      g1_layer_ff <= d_layer_ff;
      g1_iso_ff   <= d_iso_ff;
      g1_xiso_ff  <= d_xiso_ff;
      g1_ph_ff    <= ph_in;
      g1_pl_ff    <= pl_in;
   end

   // Exponent x: integer part sets the shift, fraction drives the root chain
   logic signed [61:0] gsum;
   logic signed [39:0] x;
   logic signed [15:0] n;
   logic signed [15:0] s_full;
   atsp_pkg::sq_type   g2_in;
   atsp_pkg::sq_type   g2_ff;

   always_comb begin
      gsum         = (62'(g1_ph_ff) <<< 15) + 62'(g1_pl_ff);
      x            = g1_iso_ff ? g1_xiso_ff : 40'(gsum >>> 24);
      n            = x[39:24];
      s_full       = atsp_pkg::N_SAT_ABOVE - n;
      g2_in        = '0;
      g2_in.valid  = g1_valid_ff;
      g2_in.last   = g1_last_ff;
      g2_in.layer  = g1_layer_ff;
      g2_in.sat    = n > atsp_pkg::N_SAT_ABOVE;
      g2_in.zero   = n < atsp_pkg::N_ZERO_BELOW;
      g2_in.s      = s_full[5:0];
      g2_in.f      = x[23:0];
      g2_in.root   = 32'h4000_0000;
   end

   always_ff @(posedge clock) begin
      if (reset) g2_ff.valid <= 1'b0;
      else g2_ff <= g2_in;
   end

   // 2^frac: chain of 24 square roots, low fraction bit first
   atsp_pkg::sq_type sq_ff [atsp_pkg::SQ_STAGES];

   genvar g;
   generate
      for (g = 0; g < atsp_pkg::SQ_STAGES; g++) begin : g_sq
         localparam int J = g / atsp_pkg::SQ_SUB;
         atsp_pkg::sq_type prev;
         atsp_pkg::sq_type load;
         atsp_pkg::sq_type sq_in;
         logic [31:0]      t;

         if (g == 0) begin : g_first
            assign prev = g2_ff;
         end else begin : g_next
            assign prev = sq_ff[g-1];
         end

         always_comb begin
            load = prev;
            t    = '0;
            if (g % atsp_pkg::SQ_SUB == 0) begin
               t         = prev.f[J] ? {prev.root[30:0], 1'b0} : {1'b0, prev.root[30:0]};
               load.rad  = {2'b00, t, 30'd0};
               load.rem  = '0;
               load.root = '0;
            end
            sq_in = atsp_pkg::sq_steps(load);
         end

         always_ff @(posedge clock) begin
            if (reset) sq_ff[g].valid <= 1'b0;
            else sq_ff[g] <= sq_in;
         end
      end
   endgenerate

   // Base pressure times mantissa, split in two partial products
   atsp_pkg::sq_type sq_end;
   logic [28:0]      rr;
   logic [33:0]      pb;
   logic             m1_valid_ff;
   logic             m1_last_ff;
   logic [atsp_pkg::LAYER_W-1:0] m1_layer_ff;
   logic             m1_sat_ff;
   logic             m1_zero_ff;
   logic [5:0]       m1_s_ff;
   logic [47:0]      m1_ph_ff;
   logic [48:0]      m1_pl_ff;

   assign sq_end = sq_ff[atsp_pkg::SQ_STAGES-1];
   assign rr     = sq_end.root[30:2];
   assign pb     = atsp_pkg::BASE_P[sq_end.layer];

   always_ff @(posedge clock) begin
      if (reset) m1_valid_ff <= 1'b0;
      else m1_valid_ff <= sq_end.valid;
      m1_last_ff  <= sq_end.last;
      m1_layer_ff <= sq_end.layer;
      m1_sat_ff   <= sq_end.sat;
      m1_zero_ff  <= sq_end.zero;
      m1_s_ff     <= sq_end.s;
      m1_ph_ff    <= 48'(pb) * 48'(rr[28:15]);
      m1_pl_ff    <= 49'(pb) * 49'(rr[14:0]);
   end

   // Shift into Q16 and saturate
   logic [63:0]                 v;
   logic [63:0]                 vs;
   logic [atsp_pkg::PRES_W-1:0] pres_in;
   logic                        rsp_strobe_ff;
   atsp_pkg::rsp_type           rsp_ff;

   always_comb begin
      v  = {1'b0, m1_ph_ff, 15'd0} + 64'(m1_pl_ff);
      vs = v >> m1_s_ff;
      if (m1_sat_ff) pres_in = atsp_pkg::P_MAX;
      else if (m1_zero_ff) pres_in = '0;
      else if (vs > 64'(atsp_pkg::P_MAX)) pres_in = atsp_pkg::P_MAX;
      else pres_in = vs[atsp_pkg::PRES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= m1_valid_ff;
      rsp_ff.pressure_q16 <= pres_in;
      rsp_ff.layer_index  <= m1_layer_ff;
      rsp_ff.last_out     <= m1_last_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Normalized mantissa keeps its top bit
   a_norm: assert property (@(posedge clock) disable iff (reset)
      lg_ff[0].valid |-> lg_ff[0].m[30])
      else $error("log2 mantissa not normalized");

   // Reported layer stays within the configured count
   a_layer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.layer_index <= atsp_pkg::LAYER_W'(NUM_LAYERS - 1))
      else $error("layer index out of range");

   // Underflowed scale gives zero pressure on the next result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      m1_valid_ff && m1_zero_ff |=> rsp_strobe && rsp_data.pressure_q16 == '0)
      else $error("underflow did not give zero pressure");

endmodule

@@ verif/tb_top.sv @@
// Testbench for the altitude to standard-pressure pipeline: stimulus, predictor, scoreboard.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Layer tables for the predictor
   localparam longint LYR_BASE [7] = '{0, 110000, 200000, 320000, 470000, 510000, 710000};
   localparam longint LYR_TEMP [7] = '{28815000, 21665000, 21665000, 22865000,
                                       27065000, 27065000, 21465000};
   localparam longint LYR_LAPSE [7] = '{-65, 0, 10, 28, 0, -28, -20};
   localparam bit     LYR_ISO [7] = '{0, 1, 0, 0, 1, 0, 0};
   localparam longint LYR_GEXP [7] = '{-88178957, 0, 573163218, 204701150, 0,
                                       -204701150, -286581609};
   localparam longint LYR_ICOEF [7] = '{0, 25013478, 0, 0, 20022797, 0, 0};
   localparam longint unsigned LYR_PB [7] = '{64'd16999514112, 64'd3797029591,
      64'd918533953, 64'd145629372, 64'd18606990, 64'd11230479, 64'd663777};
   localparam longint unsigned PRES_SAT = 64'd134217727;
   localparam int LATENCY = 225;
   localparam int CYCLE_LIMIT = 400000;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // log2 in Q24 by repeated squaring of a Q30 mantissa
   function automatic longint log2_fix(input longint unsigned v);
      int              e;
      longint unsigned m;
      longint          fr;
      e  = 0;
      fr = 0;
      for (int b = 0; b < 64; b++) if (v[b]) e = b;
      m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m  = m >> 1;
            fr = fr | (64'sd1 << i);
         end
      end
      return longint'(e) * 16777216 + fr;
   endfunction

   // Base pressure times 2^x, result Q16 hPa with saturation
   function automatic longint unsigned scale_pres(input longint unsigned pb, input longint x);
      longint          n, s;
      longint unsigned f, r, t, v;
      n = x >>> 24;
      f = longint'(x - n * 16777216);
      r = 64'd1 << 30;
      for (int i = 0; i < 24; i++) begin
         t = f[i] ? (r << 1) : r;
         r = int_sqrt(t << 30);
      end
      s = 36 - n;
      if (s < 0) return PRES_SAT;
      if (s > 63) return 0;
      v = (pb * (r >> 2)) >> s;
      return (v > PRES_SAT) ? PRES_SAT : v;
   endfunction

   function automatic atsp_pkg::rsp_type predict_pressure(input atsp_pkg::req_type rq);
      atsp_pkg::rsp_type o;
      longint  alt, dh, x, tk;
      int      lyr;
      alt = longint'(rq.altitude_dm);
      lyr = 0;
      for (int i = 1; i < atsp_pkg::NUM_LAYERS_DEF; i++) if (alt >= LYR_BASE[i]) lyr = i;
      dh = alt - LYR_BASE[lyr];
      if (LYR_ISO[lyr]) begin
         x = (-(dh * LYR_ICOEF[lyr])) >>> 16;
      end else begin
         tk = LYR_TEMP[lyr] + LYR_LAPSE[lyr] * dh;
         if (tk < 1) tk = 1;
         x = ((log2_fix(LYR_TEMP[lyr]) - log2_fix(tk)) * LYR_GEXP[lyr]) >>> 24;
      end
      o.pressure_q16 = atsp_pkg::PRES_W'(scale_pres(LYR_PB[lyr], x));
      o.layer_index  = atsp_pkg::LAYER_W'(lyr);
      o.last_out     = rq.last_in;
      return o;
   endfunction

   // Scoreboard: queue of predicted pressure results
   class pressure_board;
      atsp_pkg::rsp_type want_q[$];
      int      errors;
      function void note_altitude(atsp_pkg::req_type rq);
         want_q.push_back(predict_pressure(rq));
      endfunction
      function void check_pressure(atsp_pkg::rsp_type got);
         atsp_pkg::rsp_type w;
         if (want_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         w = want_q.pop_front();
         if (got.pressure_q16 !== w.pressure_q16 || got.layer_index !== w.layer_index ||
             got.last_out !== w.last_out) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", w, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   atsp_pkg::req_type req_data = '0;
   logic    rsp_strobe;
   atsp_pkg::rsp_type rsp_data;
   pressure_board board = new();
   int      send_idle = 0;
   int      cycles = 0;

   altitude_to_standard_pressure dut (.*);

   always #6 clock = ~clock;

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_pressure(rsp_data);
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // One transfer, with random idle cycles ahead of it
   task automatic send_altitude(input logic signed [atsp_pkg::ALT_W-1:0] alt,
                                input logic lst);
      atsp_pkg::req_type rq;
      rq.altitude_dm = alt;
      rq.last_in     = lst;
      while ($urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_altitude(rq);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (board.want_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [atsp_pkg::ALT_W-1:0] rand_altitude();
      int sel, b;
      sel = $urandom_range(99);
      if (sel < 25) return atsp_pkg::ALT_W'($urandom);
      if (sel < 50) begin
         b = $urandom_range(6);
         return atsp_pkg::ALT_W'(LYR_BASE[b] + $signed($urandom_range(400)) - 200);
      end
      return atsp_pkg::ALT_W'($signed($urandom_range(1010000)) - 10000);
   endfunction

   initial begin
      logic signed [atsp_pkg::ALT_W-1:0] dir_alt [$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, range ends, each layer base and the cell below it
      dir_alt = '{-21'sd1048576, 21'sd1048575, -21'sd10000, -21'sd1, 21'sd0, 21'sd1000000};
      for (int i = 1; i < 7; i++) begin
         dir_alt.push_back(atsp_pkg::ALT_W'(LYR_BASE[i] - 1));
         dir_alt.push_back(atsp_pkg::ALT_W'(LYR_BASE[i]));
      end
      dir_alt.push_back(21'sd710001);
      foreach (dir_alt[i]) send_altitude(dir_alt[i], i[0]);
      drain_results();

      // Random phases: sender busy then quiet, then back to back
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 14 : (ph == 1) ? 55 : 0;
         for (int k = 0; k < 215; k++) begin
            send_altitude(rand_altitude(), 1'($urandom));
            if (k == 100) drain_results();
         end
         drain_results();
      end

      repeat (LATENCY + 20) @(posedge clock);
      if (board.errors == 0 && board.want_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

@@ altitude_to_standard_pressure.f @@
src/atsp_pkg.sv
src/altitude_to_standard_pressure.sv
verif/tb_top.sv
